FILE: rtl/kact_pkg.sv
package kact_pkg;

  localparam int SaltWidth   = 64;
  localparam int TimeWidth   = 32;
  localparam int CreditWidth = 8;
  localparam int IntvWidth   = 16;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 16;

  localparam logic [CreditWidth-1:0] RST_INIT_CREDIT = 8'd10;
  localparam logic [IntvWidth-1:0]   RST_INTERVAL    = 16'd10;
  localparam logic [TimeWidth-1:0]   RST_NEXT_REFILL = 32'd10;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BLOCKED   = 2'd1,
    STAT_NOT_READY = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_ATTEMPT = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENABLED     = 2'd0,
    CFG_INIT_CREDIT = 2'd1,
    CFG_INTERVAL    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic                   busy;
    logic                   done;
    status_t                status;
    logic [CreditWidth-1:0] credit;
    logic                   new_key;
  } link_t;

endpackage

FILE: rtl/kact_ifs.sv
interface kact_req_if
  import kact_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [0:0]           opcode;
  logic [SaltWidth-1:0] salt_key;
  logic [TimeWidth-1:0] tick_time;

  modport source (output valid, opcode, salt_key, tick_time, input ready);
  modport sink   (input valid, opcode, salt_key, tick_time, output ready);
endinterface

interface kact_rsp_if
  import kact_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [CreditWidth-1:0] credit_left;
  logic                   new_key;
  logic                   refilled;

  modport source (output valid, status, credit_left, new_key, refilled, input ready);
  modport sink   (input valid, status, credit_left, new_key, refilled, output ready);
endinterface

FILE: rtl/kact_cell.sv
module kact_cell
  import kact_pkg::*;
#(
  parameter int KEY_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [KEY_BITS-1:0]    key,
  input  logic [CreditWidth-1:0] init_credit,
  input  logic                   refill,
  input  link_t                  lin,
  output link_t                  lout
);

  logic                   valid;
  logic [KEY_BITS-1:0]    ekey;
  logic [CreditWidth-1:0] credit;
  link_t                  lout_next;
  logic                   ins;
  logic                   hit;

  always_comb begin
    lout_next = lin;
    ins       = 1'b0;
    hit       = 1'b0;
    if (lin.busy && !lin.done) begin
      if (!valid) begin
        ins               = 1'b1;
        lout_next.done    = 1'b1;
        lout_next.status  = STAT_OK;
        lout_next.credit  = init_credit;
        lout_next.new_key = 1'b1;
      end else if (ekey == key) begin
        hit            = 1'b1;
        lout_next.done = 1'b1;
        if (credit == '0) begin
          lout_next.status = STAT_BLOCKED;
          lout_next.credit = '0;
        end else begin
          lout_next.status = STAT_OK;
          lout_next.credit = credit - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      lout.busy <= 1'b0;
    end else begin
      if (ins) valid <= 1'b1;
      lout.busy <= lout_next.busy;
    end
    lout.done    <= lout_next.done;
    lout.status  <= lout_next.status;
    lout.credit  <= lout_next.credit;
    lout.new_key <= lout_next.new_key;
    if (ins) begin
      ekey   <= key;
      credit <= init_credit;
    end else if (hit && credit != '0) begin
      credit <= credit - 1'b1;
    end else if (refill && valid) begin
      credit <= init_credit;
    end
  end

endmodule

FILE: rtl/keyed_attempt_credit_table.sv
// Per-key attempt credit table. Attempts and ticks arrive as beats on req, one
// result beat per request on rsp. Entries fill from the lowest slot upward and
// are never freed. An attempt sends a token down a chain of TABLE_ENTRIES cells,
// one cell per cycle; the cell holding the key or the first empty cell settles
// it, and the token still runs to the end of the chain before the result is
// registered on rsp; the next request is taken at the earliest together with
// that result. Ticks and requests while disabled get a registered result beat
// straight from the accepting edge; a refill rewrites every credit at the
// accepting edge.
// One request is handled at a time. Config writes are only legal while idle.
module keyed_attempt_credit_table
  import kact_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  kact_req_if.sink                req,
  kact_rsp_if.source              rsp,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_idx,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                   enabled;
  logic [CreditWidth-1:0] init_credit;
  logic [IntvWidth-1:0]   interval;
  logic [TimeWidth-1:0]   next_refill;
  logic [KEY_BITS-1:0]    key;
  logic                   refill;
  logic                   req_fire;
  logic                   tick_due;

  link_t link [TABLE_ENTRIES+1];

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign tick_due  = req.tick_time > next_refill;
  assign refill    = req_fire && enabled && (req.opcode == OP_TICK) && tick_due;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire && enabled && req.opcode == OP_ATTEMPT) state_next = S_WALK;
      S_WALK: if (link[TABLE_ENTRIES].busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enabled     <= 1'b0;
      init_credit <= RST_INIT_CREDIT;
      interval    <= RST_INTERVAL;
      next_refill <= RST_NEXT_REFILL;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ENABLED:     enabled     <= cfg_data[0];
          CFG_INIT_CREDIT: init_credit <= cfg_data[CreditWidth-1:0];
          CFG_INTERVAL:    interval    <= cfg_data[IntvWidth-1:0];
          default: ;
        endcase
      end
      if (refill) next_refill <= next_refill + {{(TimeWidth-IntvWidth){1'b0}}, interval};
      if (req_fire && (!enabled || req.opcode == OP_TICK)) begin
        rsp.valid <= 1'b1;
      end else if (state == S_WALK && link[TABLE_ENTRIES].busy) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    link[0].busy    <= !rst && req_fire && enabled && (req.opcode == OP_ATTEMPT);
    link[0].done    <= 1'b0;
    link[0].status  <= STAT_OK;
    link[0].credit  <= '0;
    link[0].new_key <= 1'b0;
    if (req_fire) key <= req.salt_key[KEY_BITS-1:0];
    if (req_fire && !enabled) begin
      rsp.status      <= STAT_NOT_READY;
      rsp.credit_left <= '0;
      rsp.new_key     <= 1'b0;
      rsp.refilled    <= 1'b0;
    end else if (req_fire && req.opcode == OP_TICK) begin
      rsp.status      <= STAT_OK;
      rsp.credit_left <= '0;
      rsp.new_key     <= 1'b0;
      rsp.refilled    <= tick_due;
    end else if (state == S_WALK && link[TABLE_ENTRIES].busy) begin
      if (link[TABLE_ENTRIES].done) begin
        rsp.status      <= link[TABLE_ENTRIES].status;
        rsp.credit_left <= link[TABLE_ENTRIES].credit;
        rsp.new_key     <= link[TABLE_ENTRIES].new_key;
      end else begin
        rsp.status      <= STAT_FULL;
        rsp.credit_left <= '0;
        rsp.new_key     <= 1'b0;
      end
      rsp.refilled <= 1'b0;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    kact_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .init_credit(init_credit),
      .refill     (refill),
      .lin        (link[i]),
      .lout       (link[i+1])
    );
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kact_pkg::*;

  localparam int Slots      = 64;
  localparam int HoldCycles = 300;

  typedef struct packed {
    status_t                status;
    logic [CreditWidth-1:0] credit;
    logic                   new_key;
    logic                   refilled;
  } verdict_t;

  class credit_ledger;
    bit                     enabled;
    logic [CreditWidth-1:0] init_credit;
    logic [IntvWidth-1:0]   interval;
    logic [TimeWidth-1:0]   next_refill;
    bit                     slot_used [Slots];
    logic [SaltWidth-1:0]   slot_key [Slots];
    logic [CreditWidth-1:0] slot_credit [Slots];
    verdict_t               expected_verdicts [$];
    int                     errors;
    int                     status_seen [4];
    int                     inserts;
    int                     refills;

    function new();
      enabled     = 1'b0;
      init_credit = RST_INIT_CREDIT;
      interval    = RST_INTERVAL;
      next_refill = RST_NEXT_REFILL;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors  = 0;
      inserts = 0;
      refills = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_ENABLED:     enabled     = data[0];
        CFG_INIT_CREDIT: init_credit = data[CreditWidth-1:0];
        CFG_INTERVAL:    interval    = data[IntvWidth-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // predict the verdict of one accepted request and update the table copy
    function void note_request(opcode_t op, logic [SaltWidth-1:0] key,
                               logic [TimeWidth-1:0] now);
      verdict_t v;
      int       hit;
      int       free_slot;
      v         = '0;
      hit       = -1;
      free_slot = -1;
      if (!enabled) begin
        v.status = STAT_NOT_READY;
      end else if (op == OP_TICK) begin
        if (now > next_refill) begin
          foreach (slot_used[i]) if (slot_used[i]) slot_credit[i] = init_credit;
          next_refill = next_refill + TimeWidth'(interval);
          v.refilled  = 1'b1;
        end
      end else begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i]) begin
            if (hit < 0 && slot_key[i] == key) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          if (slot_credit[hit] == '0) begin
            v.status = STAT_BLOCKED;
          end else begin
            slot_credit[hit] = slot_credit[hit] - 1'b1;
            v.credit         = slot_credit[hit];
          end
        end else if (free_slot >= 0) begin
          slot_used[free_slot]   = 1'b1;
          slot_key[free_slot]    = key;
          slot_credit[free_slot] = init_credit;
          v.credit               = init_credit;
          v.new_key              = 1'b1;
        end else begin
          v.status = STAT_FULL;
        end
      end
      expected_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] st, logic [CreditWidth-1:0] cr,
                                logic nk, logic rf);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%t: unexpected result beat: status %0d credit %0d new_key %0d refilled %0d",
                 $time, st, cr, nk, rf);
        return;
      end
      want = expected_verdicts.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (cr !== want.credit) begin
        errors++;
        $display("%t: credit_left expected %0d actual %0d", $time, want.credit, cr);
      end
      if (nk !== want.new_key) begin
        errors++;
        $display("%t: new_key expected %0d actual %0d", $time, want.new_key, nk);
      end
      if (rf !== want.refilled) begin
        errors++;
        $display("%t: refilled expected %0d actual %0d", $time, want.refilled, rf);
      end
      if (!$isunknown(st)) status_seen[st]++;
      if (nk === 1'b1) inserts++;
      if (rf === 1'b1) refills++;
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  cfg_idx_t                cfg_idx;
  logic [CfgDataWidth-1:0] cfg_data;

  kact_req_if req_if ();
  kact_rsp_if rsp_if ();

  credit_ledger         ledger = new();
  bit                   idling = 1'b1;
  int                   hold_asked = 0;
  int                   hold_served = 0;
  int                   hold_left = 0;
  int                   stall_left = 0;
  logic [SaltWidth-1:0] key_pool [Slots];

  keyed_attempt_credit_table dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: check accepted beats, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      ledger.check_verdict(rsp_if.status, rsp_if.credit_left, rsp_if.new_key,
                           rsp_if.refilled);
    end
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic offer_beat(opcode_t op, logic [SaltWidth-1:0] key,
                            logic [TimeWidth-1:0] now);
    if (idling && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.salt_key  <= key;
    req_if.tick_time <= now;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    ledger.note_request(op, key, now);
  endtask

  task automatic offer_attempt(logic [SaltWidth-1:0] key);
    offer_beat(OP_ATTEMPT, key, $urandom);
  endtask

  task automatic offer_tick(logic [TimeWidth-1:0] now);
    offer_beat(OP_TICK, {$urandom, $urandom}, now);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataWidth'(value);
    @(posedge clk);
    ledger.write_reg(idx, CfgDataWidth'(value));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly near the refill boundary, sometimes anywhere
  function automatic logic [TimeWidth-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return ledger.next_refill - 2 + $urandom_range(0, 4);
    if (r == 9) return $urandom;
    return ledger.next_refill - $urandom_range(0, ledger.interval);
  endfunction

  task automatic random_run(int count, int keys_in_use, int fresh_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) offer_tick(pick_time());
      else if ($urandom_range(0, 99) < fresh_pct) offer_attempt({$urandom, $urandom});
      else if ($urandom_range(0, 1) == 0) offer_attempt(key_pool[$urandom_range(0, 3)]);
      else offer_attempt(key_pool[$urandom_range(0, keys_in_use - 1)]);
    end
  endtask

  initial begin
    int unsigned          credit_set [5];
    int unsigned          interval_set [5];
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_ENABLED;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_ATTEMPT;
    req_if.salt_key     = '0;
    req_if.tick_time    = '0;
    rsp_if.ready        = 1'b0;
    credit_set          = '{2, 3, 255, 0, $urandom_range(1, 255)};
    interval_set        = '{1, 100, 65535, 7, $urandom_range(1, 65535)};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < Slots; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset
    offer_attempt(key_pool[0]);
    offer_tick(32'd11);
    offer_attempt(key_pool[1]);
    drain();

    set_reg(CFG_ENABLED, 1);
    offer_attempt(key_pool[0]);
    offer_attempt(key_pool[0]);
    offer_tick(32'd0);
    offer_tick(32'd10);
    offer_tick(32'd11);
    offer_attempt(key_pool[0]);
    offer_tick('1);
    drain();

    set_reg(CFG_INIT_CREDIT, 255);
    set_reg(CFG_INTERVAL, 65535);
    offer_attempt(key_pool[1]);
    offer_attempt(key_pool[1]);
    offer_tick(32'd31);
    drain();

    // credit runs out, then blocked
    set_reg(CFG_INIT_CREDIT, 1);
    offer_attempt(key_pool[3]);
    offer_attempt(key_pool[3]);
    offer_attempt(key_pool[3]);
    drain();

    // zero credit on insert
    set_reg(CFG_INIT_CREDIT, 0);
    offer_attempt(key_pool[2]);
    offer_attempt(key_pool[2]);
    drain();

    // zero interval keeps refilling
    set_reg(CFG_INTERVAL, 0);
    offer_tick(ledger.next_refill + 1);
    offer_tick(ledger.next_refill + 1);
    offer_tick(ledger.next_refill);
    drain();

    for (int p = 0; p < 5; p++) begin
      set_reg(CFG_INIT_CREDIT, credit_set[p]);
      set_reg(CFG_INTERVAL, interval_set[p]);
      idling = (p != 2);
      if (p == 0) hold_asked++;
      random_run(220, 48, 0);
      drain();
    end
    idling = 1'b1;

    set_reg(CFG_ENABLED, 0);
    random_run(20, 48, 0);
    drain();
    set_reg(CFG_ENABLED, 1);
    set_reg(CFG_INIT_CREDIT, 4);
    set_reg(CFG_INTERVAL, 50);

    // fill the table, then overflow it
    for (int i = 0; i < Slots; i++) offer_attempt(key_pool[i]);
    for (int i = 0; i < 3; i++) offer_attempt({$urandom, $urandom});
    drain();

    for (int p = 0; p < 2; p++) begin
      set_reg(CFG_INIT_CREDIT, $urandom_range(0, 255));
      set_reg(CFG_INTERVAL, $urandom_range(1, 65535));
      random_run(250, Slots, 15);
      drain();
    end

    // last stretch back to back
    idling = 1'b0;
    random_run(60, Slots, 15);
    offer_tick(ledger.next_refill);
    offer_tick(ledger.next_refill + 1);
    offer_attempt(key_pool[0]);
    drain();
    repeat (80) @(posedge clk);

    $display("results: %0d ok, %0d blocked, %0d not_ready, %0d table_full",
             ledger.status_seen[STAT_OK], ledger.status_seen[STAT_BLOCKED],
             ledger.status_seen[STAT_NOT_READY], ledger.status_seen[STAT_FULL]);
    $display("%0d keys inserted, %0d refills, full table and long stall seen, errors %0d",
             ledger.inserts, ledger.refills, ledger.errors);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("keyed_attempt_credit_table regression: pass");
    end else begin
      $display("keyed_attempt_credit_table regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout waiting for beats, %0d results outstanding", ledger.pending());
    $display("keyed_attempt_credit_table regression: fail");
    $finish;
  end

endmodule
